>>> hw/rtl/mtw_pkg.sv
`default_nettype none
package mtw_pkg;

   localparam int STATE_WORDS  = 624;
   localparam int TWIST_OFFSET = 397;
   localparam int LANES        = 8;
   localparam int WORD_W       = 32;
   localparam int ADDR_W       = 10;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_WORDS - 1);
   localparam logic [ADDR_W-1:0] END_POS   = ADDR_W'(STATE_WORDS);
   localparam logic [ADDR_W-1:0] FAR_OFS   = ADDR_W'(TWIST_OFFSET);

   localparam logic [WORD_W-1:0] MATRIX_A   = 32'h9908_B0DF;
   localparam logic [WORD_W-1:0] UPPER_BIT  = 32'h8000_0000;
   localparam logic [WORD_W-1:0] LOWER_BITS = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] SEED_MULT  = 32'h6C07_8965;
   localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9D2C_5680;
   localparam logic [WORD_W-1:0] TEMPER_C   = 32'hEFC6_0000;

   localparam logic CMD_SEED = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEED_W0,
      S_SEED_MUL,
      S_SEED_WR,
      S_TW_LOAD,
      S_TW_LOADW,
      S_TW_RD,
      S_TW_WR,
      S_DRAW_RD,
      S_DRAW_OUT
   } state_type;

   typedef enum logic [1:0] {
      WSRC_SEED,
      WSRC_INIT,
      WSRC_TWIST
   } wsrc_type;

   typedef struct packed {
      logic              load_seed;
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
      logic              we;
      logic [ADDR_W-1:0] waddr;
      wsrc_type          wsrc;
      logic              prod_step;
      logic              cur_load;
      logic              out_load;
      logic              mark_seeded;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

   function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] y;
      y = x ^ (x >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] cur,
                                                    input logic [WORD_W-1:0] nxt,
                                                    input logic [WORD_W-1:0] far);
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] r;
      y = (cur & UPPER_BIT) | (nxt & LOWER_BITS);
      r = far ^ (y >> 1);
      if (y[0]) begin
         r = r ^ MATRIX_A;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/mersenne_twister_8lane.sv
// Eight MT19937 generators run side by side, one 624-word RAM per lane. A beat with
// req_tuser = 0 seeds all lanes and gives no result; seeding writes
// the seed as word 0, then fills each further word with a multiply step and a write.
// A beat with req_tuser = 1 draws one tempered word per lane, after a word-by-word
// twist of the state when it is used up (first draw after a seed, then every 624th).
// The twist handles one state word at a time, reading the next and far words through
// the two read ports of the lane RAM. Draws before the first seed return zero.
`default_nettype none
module mersenne_twister_8lane
   import mtw_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [0:0]              req_tuser,  // command
   input  wire logic [LANES*WORD_W-1:0] req_tdata,  // seed_lane0 .. seed_lane7
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic      [LANES*WORD_W-1:0] rsp_tdata   // rand_lane0 .. rand_lane7
);

   cmd_type    cmd;
   status_type status;

   mtw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_command(req_tuser[0]),
      .status     (status),
      .cmd        (cmd)
   );

   mtw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .seed_data (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_data  (rsp_tdata)
   );

endmodule
`default_nettype wire

>>> hw/rtl/mtw_ram.sv
`default_nettype none
module mtw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 624
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic      [WIDTH-1:0]         rdata_a,
   output logic      [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule
`default_nettype wire

>>> hw/rtl/mtw_ctrl.sv
`default_nettype none
module mtw_ctrl
   import mtw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic       req_command,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic              accept;
   logic [ADDR_W-1:0] far_sum;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign far_sum    = idx_ff + FAR_OFS;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_command == CMD_SEED) begin
                  state_in = S_SEED_W0;
               end else if (pos_ff >= END_POS) begin
                  state_in = S_TW_LOAD;
               end else begin
                  state_in = S_DRAW_RD;
               end
            end
         end
         S_SEED_W0: begin
            idx_in   = ADDR_W'(1);
            state_in = S_SEED_MUL;
         end
         S_SEED_MUL: state_in = S_SEED_WR;
         S_SEED_WR: begin
            if (idx_ff == LAST_ADDR) begin
               pos_in   = END_POS;
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               state_in = S_SEED_MUL;
            end
         end
         S_TW_LOAD: begin
            idx_in   = '0;
            state_in = S_TW_LOADW;
         end
         S_TW_LOADW: state_in = S_TW_RD;
         S_TW_RD:    state_in = S_TW_WR;
         S_TW_WR: begin
            if (idx_ff == LAST_ADDR) begin
               pos_in   = '0;
               state_in = S_DRAW_RD;
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               state_in = S_TW_RD;
            end
         end
         S_DRAW_RD: state_in = S_DRAW_OUT;
         S_DRAW_OUT: begin
            if (!status.out_busy) begin
               pos_in   = pos_ff + ADDR_W'(1);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.wsrc      = WSRC_TWIST;
      cmd.load_seed = accept && (req_command == CMD_SEED);
      unique case (state_ff)
         S_SEED_W0: begin
            cmd.we    = 1'b1;
            cmd.waddr = '0;
            cmd.wsrc  = WSRC_SEED;
         end
         S_SEED_MUL: cmd.prod_step = 1'b1;
         S_SEED_WR: begin
            cmd.we          = 1'b1;
            cmd.waddr       = idx_ff;
            cmd.wsrc        = WSRC_INIT;
            cmd.mark_seeded = (idx_ff == LAST_ADDR);
         end
         S_TW_LOAD:  cmd.addr_a   = '0;
         S_TW_LOADW: cmd.cur_load = 1'b1;
         S_TW_RD: begin
            cmd.addr_a = (idx_ff == LAST_ADDR) ? '0 : idx_ff + ADDR_W'(1);
            cmd.addr_b = (far_sum >= END_POS) ? far_sum - END_POS : far_sum;
         end
         S_TW_WR: begin
            cmd.we    = 1'b1;
            cmd.waddr = idx_ff;
            cmd.wsrc  = WSRC_TWIST;
         end
         S_DRAW_RD: cmd.addr_a = pos_ff;
         S_DRAW_OUT: begin
            cmd.addr_a   = pos_ff;
            cmd.out_load = !status.out_busy;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         pos_ff   <= END_POS;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pos_ff   <= pos_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/mtw_datapath.sv
`default_nettype none
module mtw_datapath
   import mtw_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cmd_type                   cmd,
   output status_type                     status,
   input  wire logic [LANES*WORD_W-1:0]   seed_data,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic      [LANES*WORD_W-1:0]   rsp_data
);

   logic [WORD_W-1:0] seed_ff [LANES];
   logic [WORD_W-1:0] prev_ff [LANES];
   logic [WORD_W-1:0] prod_ff [LANES];
   logic [WORD_W-1:0] cur_ff  [LANES];
   logic [WORD_W-1:0] out_ff  [LANES];
   logic [WORD_W-1:0] wdata   [LANES];
   logic [WORD_W-1:0] rd_a    [LANES];
   logic [WORD_W-1:0] rd_b    [LANES];
   logic              valid_ff, valid_in;
   logic              seeded_ff;

   assign status.out_busy = valid_ff && !rsp_tready;
   assign rsp_tvalid      = valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         seeded_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.mark_seeded) begin
            seeded_ff <= 1'b1;
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [WORD_W-1:0] mix;

      assign mix = prev_ff[l] ^ (prev_ff[l] >> 30);

      always_comb begin
         case (cmd.wsrc)
            WSRC_SEED: wdata[l] = seed_ff[l];
            WSRC_INIT: wdata[l] = prod_ff[l] + {{(WORD_W-ADDR_W){1'b0}}, cmd.waddr};
            default:   wdata[l] = twist_word(cur_ff[l], rd_a[l], rd_b[l]);
         endcase
      end

      mtw_ram #(
         .WIDTH(WORD_W),
         .DEPTH(STATE_WORDS)
      ) u_ram (
         .clock  (clock),
         .we     (cmd.we),
         .waddr  (cmd.waddr),
         .wdata  (wdata[l]),
         .raddr_a(cmd.addr_a),
         .raddr_b(cmd.addr_b),
         .rdata_a(rd_a[l]),
         .rdata_b(rd_b[l])
      );

      always_ff @(posedge clock) begin
         if (cmd.load_seed) begin
            seed_ff[l] <= seed_data[l*WORD_W +: WORD_W];
         end
         if (cmd.we && (cmd.wsrc != WSRC_TWIST)) begin
            prev_ff[l] <= wdata[l];
         end
         if (cmd.prod_step) begin
            prod_ff[l] <= mix * SEED_MULT;
         end
         if (cmd.cur_load || (cmd.we && (cmd.wsrc == WSRC_TWIST))) begin
            cur_ff[l] <= rd_a[l];
         end
         if (cmd.out_load) begin
            out_ff[l] <= seeded_ff ? temper(rd_a[l]) : '0;
         end
      end

      assign rsp_data[l*WORD_W +: WORD_W] = out_ff[l];
   end

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`default_nettype none
module tb_top;
   import mtw_pkg::*;

   localparam int LIMIT_CYCLES = 1500000;
   localparam int RANDOM_ITEMS = 1325;
   localparam logic [31:0] INIT_MULT = 32'h6C07_8965;
   localparam logic [31:0] TWIST_MAT = 32'h9908_B0DF;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [0:0]              req_tuser;
   logic [LANES*WORD_W-1:0] req_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [LANES*WORD_W-1:0] rsp_tdata;

   logic [31:0]             gen_words [LANES][STATE_WORDS];
   int unsigned             gen_pos;
   logic [LANES*WORD_W-1:0] pending_draws [$];
   int unsigned             fail_count;
   int unsigned             cycle_count;
   int unsigned             burst_left;
   int unsigned             ready_mode;
   int unsigned             ready_tick;

   mersenne_twister_8lane dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [31:0] tempered(input logic [31:0] x);
      logic [31:0] y;
      y = x ^ (x >> 11);
      y = y ^ ((y << 7) & 32'h9D2C_5680);
      y = y ^ ((y << 15) & 32'hEFC6_0000);
      y = y ^ (y >> 18);
      return y;
   endfunction

   task automatic load_seeds(input logic [LANES*WORD_W-1:0] seeds);
      logic [31:0] p;
      for (int l = 0; l < LANES; l++) begin
         gen_words[l][0] = seeds[l*WORD_W +: WORD_W];
         for (int i = 1; i < STATE_WORDS; i++) begin
            p = gen_words[l][i-1];
            gen_words[l][i] = INIT_MULT * (p ^ (p >> 30)) + 32'(i);
         end
      end
      gen_pos = STATE_WORDS;
   endtask

   task automatic regenerate();
      logic [31:0] y;
      logic [31:0] r;
      for (int l = 0; l < LANES; l++) begin
         for (int i = 0; i < STATE_WORDS; i++) begin
            y = (gen_words[l][i] & 32'h8000_0000)
              | (gen_words[l][(i + 1) % STATE_WORDS] & 32'h7FFF_FFFF);
            r = gen_words[l][(i + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1);
            if (y[0]) begin
               r = r ^ TWIST_MAT;
            end
            gen_words[l][i] = r;
         end
      end
      gen_pos = 0;
   endtask

   task automatic predict_draw();
      logic [LANES*WORD_W-1:0] words;
      if (gen_pos >= STATE_WORDS) begin
         regenerate();
      end
      for (int l = 0; l < LANES; l++) begin
         words[l*WORD_W +: WORD_W] = tempered(gen_words[l][gen_pos]);
      end
      gen_pos++;
      pending_draws.push_back(words);
   endtask

   // one beat; valid stays high afterwards unless a gap follows
   task automatic send_beat(input logic cmd, input logic [LANES*WORD_W-1:0] seeds);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= seeds;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (cmd == CMD_SEED) begin
         load_seeds(seeds);
      end else begin
         predict_draw();
      end
   endtask

   function automatic logic [LANES*WORD_W-1:0] random_seeds();
      logic [LANES*WORD_W-1:0] s;
      for (int l = 0; l < LANES; l++) begin
         case ($urandom_range(0, 9))
            0: s[l*WORD_W +: WORD_W] = '0;
            1: s[l*WORD_W +: WORD_W] = '1;
            default: s[l*WORD_W +: WORD_W] = $urandom;
         endcase
      end
      return s;
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_draws.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic test_unseeded_draws();
      for (int k = 0; k < 4; k++) send_beat(CMD_DRAW, random_seeds());
   endtask

   task automatic test_seed_extremes();
      send_beat(CMD_SEED, '0);
      for (int k = 0; k < 3; k++) send_beat(CMD_DRAW, '0);
      send_beat(CMD_SEED, '1);
      send_beat(CMD_DRAW, '0);
      send_beat(CMD_SEED, {LANES{32'hAAAA_AAAA}});
      send_beat(CMD_SEED, {LANES{32'h5555_5555}});
      for (int k = 0; k < 3; k++) send_beat(CMD_DRAW, '1);
      send_beat(CMD_SEED, random_seeds());
      send_beat(CMD_DRAW, '0);
   endtask

   task automatic test_random_runs();
      int unsigned sent;
      int unsigned run_len;
      bit          first;
      sent  = 0;
      first = 1;
      while (sent < RANDOM_ITEMS) begin
         send_beat(CMD_SEED, random_seeds());
         sent++;
         if (first || $urandom_range(0, 9) == 0) begin
            run_len = $urandom_range(600, 700);
         end else begin
            run_len = $urandom_range(0, 60);
         end
         first = 0;
         for (int k = 0; k < run_len; k++) begin
            send_beat(CMD_DRAW, random_seeds());
            sent++;
            if (k == 300) begin
               wait_drained();
            end
         end
      end
   endtask

   // receiver stall pattern, switching at random between four modes
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_tick <= 0;
         ready_mode <= 0;
      end else begin
         ready_tick <= ready_tick + 1;
         if (ready_tick % 64 == 63) begin
            ready_mode <= $urandom_range(0, 3);
         end
         case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= (ready_tick % 4 == 0);
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      logic [LANES*WORD_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_draws.size() == 0) begin
            $error("unexpected beat rsp_tdata=%h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_draws.pop_front();
            for (int l = 0; l < LANES; l++) begin
               if (rsp_tdata[l*WORD_W +: WORD_W] !== want[l*WORD_W +: WORD_W]) begin
                  $error("rand_lane%0d expected %h actual %h", l,
                         want[l*WORD_W +: WORD_W], rsp_tdata[l*WORD_W +: WORD_W]);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = CMD_DRAW;
      req_tdata   = '0;
      fail_count  = 0;
      cycle_count = 0;
      burst_left  = 0;
      for (int l = 0; l < LANES; l++) begin
         for (int i = 0; i < STATE_WORDS; i++) gen_words[l][i] = '0;
      end
      gen_pos = STATE_WORDS;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unseeded_draws();
      test_seed_extremes();
      test_random_runs();
      wait_drained();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
hw/rtl/mtw_pkg.sv
hw/rtl/mtw_ram.sv
hw/rtl/mtw_ctrl.sv
hw/rtl/mtw_datapath.sv
hw/rtl/mersenne_twister_8lane.sv
dv/tb_top.sv
